@@ src/sfs_pkg.sv @@
package sfs_pkg;

  // input item modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_LOOKUP = 3'd3;
  localparam logic [2:0] MODE_WRITE  = 3'd4;

  // animation methods
  localparam logic [2:0] METH_STOP      = 3'd0;
  localparam logic [2:0] METH_FWD_LOOP  = 3'd1;
  localparam logic [2:0] METH_REV_LOOP  = 3'd2;
  localparam logic [2:0] METH_FWD_ONCE  = 3'd3;
  localparam logic [2:0] METH_REV_ONCE  = 3'd4;
  localparam logic [2:0] METH_OSC       = 3'd5;
  localparam logic [2:0] METH_CUST_LOOP = 3'd6;
  localparam logic [2:0] METH_CUST_ONCE = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_RANGE_TOP    = 3'd0;
  localparam logic [2:0] REG_RANGE_BOTTOM = 3'd1;
  localparam logic [2:0] REG_INTERVAL     = 3'd2;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd3;
  localparam logic [2:0] REG_U_STEP       = 3'd4;
  localparam logic [2:0] REG_V_STEP       = 3'd5;
  localparam logic [2:0] REG_BASE_UV      = 3'd6;
  localparam logic [2:0] REG_CUSTOM_LEN   = 3'd7;

  localparam logic [16:0] TICK_MAX  = 17'd131071;
  localparam logic [16:0] UV_MAX    = 17'd131071;
  localparam int          DIV_STEPS = 8;  // one step per pattern bit

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] method;
    logic [7:0] pattern;
    logic [3:0] table_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  current_pattern;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        animating;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture accepted item
    logic exec;      // state update, divider init
    logic div_step;  // one restoring division step
    logic mul;       // column and row products
    logic fin;       // base add, saturate, load result register
  } ctl_cmd_t;

endpackage

@@ src/sfs_ram.sv @@
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sfs_ctrl.sv @@
module sfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sfs_pkg::ctl_cmd_t cmd
);
  import sfs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  localparam int CW = $clog2(DIV_STEPS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.load     = in_valid && (state_r == S_IDLE);
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/sfs_dp.sv @@
module sfs_dp #(
  parameter int CUSTOM_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfs_pkg::ctl_cmd_t  cmd,
  input  sfs_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output sfs_pkg::out_item_t out_data
);
  import sfs_pkg::*;

  localparam int PW = (CUSTOM_DEPTH > 1) ? $clog2(CUSTOM_DEPTH) : 1;

  // configuration
  logic [7:0]  range_top_r, range_bottom_r;
  logic [15:0] interval_r;
  logic [8:0]  column_count_r;
  logic [16:0] u_step_r, v_step_r;
  logic [31:0] base_uv_r;
  logic [4:0]  custom_len_r;

  // sequencer state
  logic [7:0]  pat_r, pat_nxt;
  logic [2:0]  meth_r, meth_nxt;
  logic        rev_r, rev_nxt;
  logic [16:0] tc_r, tc_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  in_item_t    item_r;
  logic [7:0]  rd_data;
  logic        tbl_we;

  // divider and products
  logic [7:0]  q_r;
  logic [8:0]  rem_r;
  logic [24:0] pu_r, pv_r;

  logic [7:0]  inc, dec, shown;
  logic [16:0] tc_inc;
  logic [8:0]  len9, next9, cols;
  logic [9:0]  trial;
  logic [25:0] sum_u, sum_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_top_r    <= 8'd0;
      range_bottom_r <= 8'd0;
      interval_r     <= 16'd1;
      column_count_r <= 9'd1;
      u_step_r       <= 17'd65536;
      v_step_r       <= 17'd65536;
      base_uv_r      <= 32'd0;
      custom_len_r   <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_TOP:    range_top_r    <= cfg_data[7:0];
        REG_RANGE_BOTTOM: range_bottom_r <= cfg_data[7:0];
        REG_INTERVAL:     interval_r     <= cfg_data[15:0];
        REG_COLUMN_COUNT: column_count_r <= cfg_data[8:0];
        REG_U_STEP:       u_step_r       <= cfg_data[16:0];
        REG_V_STEP:       v_step_r       <= cfg_data[16:0];
        REG_BASE_UV:      base_uv_r      <= cfg_data;
        REG_CUSTOM_LEN:   custom_len_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  sfs_ram #(
    .WIDTH (8),
    .DEPTH (CUSTOM_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (PW'(item_r.table_index)),
    .wdata (item_r.pattern),
    .raddr (pos_r),
    .rdata (rd_data)
  );

  assign inc    = pat_r + 8'd1;
  assign dec    = pat_r - 8'd1;
  assign tc_inc = (tc_r != TICK_MAX) ? tc_r + 17'd1 : tc_r;
  assign len9   = (9'(custom_len_r) > 9'(CUSTOM_DEPTH)) ? 9'(CUSTOM_DEPTH)
                                                        : 9'(custom_len_r);
  assign next9  = 9'(pos_r) + 9'd1;

  always_comb begin
    pat_nxt  = pat_r;
    meth_nxt = meth_r;
    rev_nxt  = rev_r;
    tc_nxt   = tc_r;
    pos_nxt  = pos_r;
    tbl_we   = 1'b0;
    if (cmd.exec) begin
      case (item_r.mode)
        MODE_TICK: begin
          tc_nxt = tc_inc;
          if (meth_r != METH_STOP && {1'b0, interval_r} < tc_inc) begin
            tc_nxt = '0;
            case (meth_r)
              METH_FWD_LOOP: pat_nxt = (range_bottom_r > pat_r) ? inc : range_top_r;
              METH_REV_LOOP: pat_nxt = (range_top_r < pat_r) ? dec : range_bottom_r;
              METH_FWD_ONCE: begin
                if (range_bottom_r > pat_r) begin
                  pat_nxt = inc;
                end else begin
                  pat_nxt  = range_bottom_r;
                  meth_nxt = METH_STOP;
                end
              end
              METH_REV_ONCE: begin
                if (range_top_r < pat_r) begin
                  pat_nxt = dec;
                end else begin
                  pat_nxt  = range_top_r;
                  meth_nxt = METH_STOP;
                end
              end
              METH_OSC: begin
                if (rev_r) begin
                  if (range_top_r < pat_r) begin
                    pat_nxt = dec;
                  end else begin
                    pat_nxt = inc;
                    rev_nxt = 1'b0;
                  end
                end else begin
                  if (range_bottom_r > pat_r) begin
                    pat_nxt = inc;
                  end else begin
                    pat_nxt = dec;
                    rev_nxt = 1'b1;
                  end
                end
              end
              METH_CUST_LOOP, METH_CUST_ONCE: begin
                if (len9 != 9'd0) begin
                  pat_nxt = (9'(pos_r) < 9'(CUSTOM_DEPTH)) ? rd_data : 8'd0;
                  pos_nxt = PW'(next9);
                  if (next9 >= len9) begin
                    pos_nxt = '0;
                    if (meth_r == METH_CUST_ONCE) begin
                      meth_nxt = METH_STOP;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        MODE_START: begin
          meth_nxt = item_r.method;
          rev_nxt  = 1'b0;
        end
        MODE_SET: begin
          pat_nxt = item_r.pattern;
        end
        MODE_WRITE: begin
          tbl_we = (9'(item_r.table_index) < 9'(CUSTOM_DEPTH));
        end
        default: ;
      endcase
    end
  end

  assign shown = (item_r.mode == MODE_LOOKUP) ? item_r.pattern : pat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= 8'd0;
      meth_r <= METH_FWD_LOOP;
      rev_r  <= 1'b0;
      tc_r   <= '0;
      pos_r  <= '0;
    end else begin
      pat_r  <= pat_nxt;
      meth_r <= meth_nxt;
      rev_r  <= rev_nxt;
      tc_r   <= tc_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // restoring divide: q = pattern / cols, rem = pattern % cols
  assign cols  = (column_count_r == 9'd0) ? 9'd1 : column_count_r;
  assign trial = {rem_r, q_r[7]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      q_r   <= shown;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, cols}) begin
        rem_r <= 9'(trial - {1'b0, cols});
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        rem_r <= trial[8:0];
        q_r   <= {q_r[6:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      pu_r <= 25'(rem_r[7:0]) * 25'(u_step_r);
      pv_r <= 25'(q_r) * 25'(v_step_r);
    end
  end

  // q_r still holds the displayed pattern's row after the divide
  assign sum_u = 26'(base_uv_r[31:16]) + 26'(pu_r);
  assign sum_v = 26'(base_uv_r[15:0]) + 26'(pv_r);

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data.current_pattern <= item_r.mode == MODE_LOOKUP ? item_r.pattern : pat_r;
      out_data.tex_u           <= (sum_u > 26'(UV_MAX)) ? UV_MAX : sum_u[16:0];
      out_data.tex_v           <= (sum_v > 26'(UV_MAX)) ? UV_MAX : sum_v[16:0];
      out_data.animating       <= (meth_r != METH_STOP);
    end
  end

endmodule

@@ src/sprite_frame_sequencer.sv @@
// Sprite-sheet frame sequencer. Each input transaction is a frame tick, a start
// command with an animation method, a set-pattern command, a UV lookup of any
// pattern, or a write of one custom-order table slot; every transaction returns
// exactly one result: the pattern shown (or the looked-up pattern), its UV corner
// in Q1.16 (base + column * u_step, base + row * v_step, saturated at 0x1FFFF),
// and an animating flag. A tick bumps a saturating counter (it counts even while
// stopped); once the counter exceeds interval_frames the pattern steps per the
// active method and the counter clears. Configuration registers (index: name):
// 0 range_top, 1 range_bottom, 2 interval_frames, 3 column_count (0 acts as 1),
// 4 u_step, 5 v_step, 6 base_uv (u in 31:16, v in 15:0), 7 custom_length; write
// them only while no transaction is in flight. Custom table slots power up
// undefined: write every slot a custom method will visit before using it.
// Sequence: the accepting edge captures the transaction, then the sequencer
// state is updated, the bit-serial restoring divider splits the pattern into
// column and row, the two UV multiplies run, and the base add and saturation
// load the result once the output register is free. in_ready is low from
// acceptance until the result is loaded into the output register and rises as
// it is loaded, so at most one transaction is in the datapath; a result
// waiting on out_ready does not stop the next transaction from being accepted.
module sprite_frame_sequencer #(
  parameter int CUSTOM_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import sfs_pkg::*;

  ctl_cmd_t cmd;

  // register writes are never stalled
  assign cfg_ready = 1'b1;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sfs_dp #(
    .CUSTOM_DEPTH (CUSTOM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

@@ bench/testbench.sv @@
module testbench;
  import sfs_pkg::*;

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  localparam int PHASES         = 12;   // configuration settings in the random part
  localparam int PHASE_ITEMS    = 105;  // transactions per setting, roughly
  localparam int SETTLE_CYCLES  = 16;   // extra idle wait after the last result
  localparam int HOLD_OFF       = 250;  // long receiver stall
  localparam int WATCHDOG_LIMIT = 3000; // cycles with no handshake at all
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] data;
  } reg_write_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // queues drained at rising edges; stimulus filled at falling edges, results at rising
  in_item_t   pending_items[$];
  reg_write_t pending_writes[$];
  out_item_t  pending_frames[$];   // expected results, oldest first

  int error_count = 0;
  int phase_items = 0;
  int idle_cycles = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall shaping
  logic long_hold_req = 1'b0;
  int   hold_left = 0;
  int   ready_style = 0;
  int   style_left = 0;
  int   rx_cycle = 0;

  // ---------------------------------------------------------------------------
  // Predictor copy of the sequencer: configuration ...
  // ---------------------------------------------------------------------------
  logic [7:0]  rng_top, rng_bot;
  logic [15:0] frame_interval;
  logic [8:0]  sheet_cols;
  logic [16:0] u_per_col, v_per_row;
  logic [31:0] base_uv;
  logic [4:0]  cust_len;

  // ... and animation state
  logic [7:0]  shown_pat;
  logic [2:0]  anim_method;
  logic        osc_back;
  logic [16:0] tick_cnt;
  logic [3:0]  cust_pos;
  logic [7:0]  cust_tbl[16];

  out_item_t   want_frame;

  // generator's view of the current range
  int gen_top = 0;
  int gen_bot = 0;

  sprite_frame_sequencer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // base + offset, clipped to the Q1.16 ceiling
  function automatic logic [16:0] sat_uv(input logic [15:0] base, input longint unsigned offs);
    longint unsigned sum;
    sum = base + offs;
    return (sum > UV_MAX) ? UV_MAX : sum[16:0];
  endfunction

  // custom order: show the slot under the cursor, then move the cursor on
  function automatic void advance_custom(input bit once);
    int unsigned len;
    int unsigned nxt;
    len = (cust_len > 16) ? 16 : cust_len;
    if (len == 0) return;
    shown_pat = cust_tbl[cust_pos];
    nxt = cust_pos + 1;
    if (nxt >= len) begin
      nxt = 0;
      if (once) anim_method = METH_STOP;
    end
    cust_pos = nxt[3:0];
  endfunction

  function automatic void step_shown_pattern();
    logic [7:0] up;
    logic [7:0] down;
    up   = shown_pat + 8'd1;
    down = shown_pat - 8'd1;
    case (anim_method)
      METH_FWD_LOOP: shown_pat = (rng_bot > shown_pat) ? up : rng_top;
      METH_REV_LOOP: shown_pat = (rng_top < shown_pat) ? down : rng_bot;
      METH_FWD_ONCE: begin
        if (rng_bot > shown_pat) shown_pat = up;
        else begin
          shown_pat = rng_bot;
          anim_method = METH_STOP;
        end
      end
      METH_REV_ONCE: begin
        if (rng_top < shown_pat) shown_pat = down;
        else begin
          shown_pat = rng_top;
          anim_method = METH_STOP;
        end
      end
      METH_OSC: begin
        if (osc_back) begin
          if (rng_top < shown_pat) shown_pat = down;
          else begin
            shown_pat = up;
            osc_back = 1'b0;
          end
        end else begin
          if (rng_bot > shown_pat) shown_pat = up;
          else begin
            shown_pat = down;
            osc_back = 1'b1;
          end
        end
      end
      METH_CUST_LOOP: advance_custom(1'b0);
      METH_CUST_ONCE: advance_custom(1'b1);
      default: ;
    endcase
  endfunction

  // apply one transaction to the predictor and return the frame it shows
  function automatic out_item_t predict_frame(input in_item_t item);
    out_item_t frame;
    logic [7:0] pat;
    int unsigned cols, col, row;
    longint unsigned offs;
    case (item.mode)
      MODE_TICK: begin
        // counter keeps running while stopped, pinned at its ceiling
        if (tick_cnt < TICK_MAX) tick_cnt = tick_cnt + 17'd1;
        if (anim_method != METH_STOP && frame_interval < tick_cnt) begin
          step_shown_pattern();
          tick_cnt = '0;
        end
      end
      MODE_START: begin
        anim_method = item.method;
        osc_back = 1'b0;
      end
      MODE_SET:   shown_pat = item.pattern;
      MODE_WRITE: cust_tbl[item.table_index] = item.pattern;
      default: ;
    endcase
    pat  = (item.mode == MODE_LOOKUP) ? item.pattern : shown_pat;
    cols = (sheet_cols == 0) ? 1 : sheet_cols;
    col  = pat % cols;
    row  = pat / cols;
    frame.current_pattern = pat;
    offs = col;
    frame.tex_u = sat_uv(base_uv[31:16], offs * u_per_col);
    offs = row;
    frame.tex_v = sat_uv(base_uv[15:0], offs * v_per_row);
    frame.animating = (anim_method != METH_STOP);
    return frame;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input transactions in bursts, register writes when queued
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      // a held transaction stays put until the handshake completes
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) burst_left--;
          else if ($urandom_range(0, 4) == 0) begin
            // long back-to-back stretch, no idling
            burst_left = $urandom_range(100, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 14);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (!cfg_valid || cfg_ready) begin
        if (pending_writes.size() != 0) begin
          {cfg_index, cfg_data} <= pending_writes.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall styles; a requested hold-off wins
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_cycle++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        hold_left = HOLD_OFF;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          ready_style = $urandom_range(0, 3);
          style_left  = $urandom_range(20, 200);
        end else begin
          style_left--;
        end
        case (ready_style)
          0:       out_ready <= 1'b1;                          // no stalls
          1:       out_ready <= $urandom_range(0, 1);          // coin flip
          2:       out_ready <= (rx_cycle % 7) < 3;            // fixed rhythm
          default: out_ready <= ($urandom_range(0, 7) == 0);   // mostly stalled
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results first, then tracks writes and new transactions,
  // all from values sampled at the same rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rng_top        = '0;
      rng_bot        = '0;
      frame_interval = 16'd1;
      sheet_cols     = 9'd1;
      u_per_col      = 17'd65536;
      v_per_row      = 17'd65536;
      base_uv        = '0;
      cust_len       = '0;
      shown_pat      = '0;
      anim_method    = METH_FWD_LOOP;
      osc_back       = 1'b0;
      tick_cnt       = '0;
      cust_pos       = '0;
      foreach (cust_tbl[i]) cust_tbl[i] = '0;
      pending_frames.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, pattern %0d",
                                    out_data.current_pattern));
        end else begin
          want_frame = pending_frames.pop_front();
          if (out_data.current_pattern !== want_frame.current_pattern)
            report_mismatch($sformatf("current_pattern %0d, expected %0d",
                                      out_data.current_pattern, want_frame.current_pattern));
          if (out_data.tex_u !== want_frame.tex_u)
            report_mismatch($sformatf("tex_u 0x%0h, expected 0x%0h",
                                      out_data.tex_u, want_frame.tex_u));
          if (out_data.tex_v !== want_frame.tex_v)
            report_mismatch($sformatf("tex_v 0x%0h, expected 0x%0h",
                                      out_data.tex_v, want_frame.tex_v));
          if (out_data.animating !== want_frame.animating)
            report_mismatch($sformatf("animating %b, expected %b",
                                      out_data.animating, want_frame.animating));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANGE_TOP:    rng_top        = cfg_data[7:0];
          REG_RANGE_BOTTOM: rng_bot        = cfg_data[7:0];
          REG_INTERVAL:     frame_interval = cfg_data[15:0];
          REG_COLUMN_COUNT: sheet_cols     = cfg_data[8:0];
          REG_U_STEP:       u_per_col      = cfg_data[16:0];
          REG_V_STEP:       v_per_row      = cfg_data[16:0];
          REG_BASE_UV:      base_uv        = cfg_data;
          REG_CUSTOM_LEN:   cust_len       = cfg_data[4:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) pending_frames.push_back(predict_frame(in_data));
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel counts as progress
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** sprite_frame_sequencer: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (called from the initial block at falling edges)
  // ---------------------------------------------------------------------------
  task automatic queue_item(input in_item_t item);
    pending_items.push_back(item);
    phase_items++;
  endtask

  task automatic directed(input logic [2:0] mode, input logic [2:0] method,
                          input logic [7:0] pat, input logic [3:0] slot);
    in_item_t item;
    item.mode        = mode;
    item.method      = method;
    item.pattern     = pat;
    item.table_index = slot;
    queue_item(item);
  endtask

  function automatic in_item_t rand_item(input logic [2:0] mode);
    in_item_t item;
    item.mode        = mode;
    item.method      = $urandom_range(0, 7);
    item.pattern     = $urandom_range(0, 255);
    item.table_index = $urandom_range(0, 15);
    return item;
  endfunction

  // garbage above the register width now and then; the block keeps the low bits
  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] junk;
    junk = $urandom();
    if (width >= 32 || $urandom_range(0, 2) != 0) return value;
    return value | (junk << width);
  endfunction

  // block is idle once nothing is queued, offered or outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || pending_frames.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    pending_writes.push_back(wr);
    @(negedge clk);
    while (pending_writes.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic load_config(input int unsigned top, input int unsigned bottom,
                             input int unsigned intv, input int unsigned cols,
                             input int unsigned us, input int unsigned vs,
                             input logic [31:0] base, input int unsigned clen);
    write_reg(REG_RANGE_TOP,    with_junk(top, 8));
    write_reg(REG_RANGE_BOTTOM, with_junk(bottom, 8));
    write_reg(REG_INTERVAL,     with_junk(intv, 16));
    write_reg(REG_COLUMN_COUNT, with_junk(cols, 9));
    write_reg(REG_U_STEP,       with_junk(us, 17));
    write_reg(REG_V_STEP,       with_junk(vs, 17));
    write_reg(REG_BASE_UV,      base);
    write_reg(REG_CUSTOM_LEN,   with_junk(clen, 5));
    gen_top = top;
    gen_bot = bottom;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t item;
    int top, bottom, span, runs, pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: one-pattern range, interval 1, one column, full-size steps.
    directed(MODE_LOOKUP, METH_STOP, 8'd255, 4'd0);  // row 255 saturates v
    directed(MODE_LOOKUP, METH_STOP, 8'd0, 4'd0);
    directed(MODE_SET, METH_STOP, 8'd0, 4'd0);
    directed(MODE_START, METH_OSC, 8'd0, 4'd0);
    repeat (2) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);  // osc turns back, 0 wraps to 255
    repeat (2) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);
    directed(MODE_START, METH_STOP, 8'd0, 4'd0);
    repeat (2) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);  // stopped, counter still runs
    directed(MODE_START, METH_CUST_LOOP, 8'd0, 4'd0);
    repeat (2) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);  // empty custom order: no move
    directed(MODE_START, METH_CUST_ONCE, 8'd0, 4'd0);
    directed(3'd7, 3'd7, 8'd255, 4'd15);                    // unused mode, all ones
    directed(MODE_WRITE, METH_STOP, 8'd255, 4'd15);
    directed(MODE_WRITE, METH_STOP, 8'd0, 4'd0);
    wait_idle();

    // Range 3..6, no wait between steps, zero columns (acts as one), max u step.
    load_config(3, 6, 0, 0, 17'h1FFFF, 17'h08000, 32'hFFFF_FFFF, 0);
    directed(MODE_SET, METH_STOP, 8'd5, 4'd0);
    directed(MODE_START, METH_FWD_ONCE, 8'd0, 4'd0);
    repeat (2) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);  // reaches bottom, stops
    directed(MODE_START, METH_REV_ONCE, 8'd0, 4'd0);
    repeat (4) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);  // walks down to top, stops
    directed(MODE_START, METH_REV_LOOP, 8'd0, 4'd0);
    repeat (2) directed(MODE_TICK, METH_STOP, 8'd0, 4'd0);  // wraps back to bottom
    wait_idle();

    // Fill the whole custom table before any custom length is enabled.
    for (int slot = 0; slot < 16; slot++) begin
      item = rand_item(MODE_WRITE);
      item.table_index = slot;
      queue_item(item);
    end
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_config(0, 255, 0, 256, 0, 0, 32'h0, 16);
        1: load_config(255, 255, 65535, 1, 65536, 65536, 32'hFFFF_FFFF, 0);
        PHASES - 1: load_config(250, 5, 2, 511, 17'h1FFFF, 17'h1FFFF, 32'h0001_0001, 31);
        default: begin
          top    = $urandom_range(0, 255);
          span   = $urandom_range(0, 15);
          bottom = (top + span > 255) ? 255 : top + span;
          if ($urandom_range(0, 5) == 0) bottom = $urandom_range(0, 255);
          load_config(top, bottom,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 3),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 17),
                      $urandom_range(0, 17'h1FFFF), $urandom_range(0, 17'h1FFFF),
                      $urandom(),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, 16));
        end
      endcase

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed run: place the pattern, start a method, then mostly ticks
          item = rand_item(MODE_SET);
          if ($urandom_range(0, 3) != 0) item.pattern = $urandom_range(gen_top, gen_bot);
          queue_item(item);
          queue_item(rand_item(MODE_START));
          runs = $urandom_range(3, 24);
          repeat (runs) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)       queue_item(rand_item(MODE_TICK));
            else if (pick == 7) queue_item(rand_item(MODE_LOOKUP));
            else if (pick == 8) queue_item(rand_item(MODE_WRITE));
            else                queue_item(rand_item(MODE_START));
          end
        end else begin
          // noise: any mode, unused ones included
          queue_item(rand_item(3'($urandom_range(0, 7))));
        end
      end

      // back up the output while the sender keeps pushing
      if (ph == 4 || ph == 8) long_hold_req = 1'b1;

      // sender pauses here until every expected result is in
      wait_idle();
    end

    if (error_count == 0) begin
      $display("** sprite_frame_sequencer: PASSED **");
    end else begin
      $display("** sprite_frame_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

@@ sprite_frame_sequencer.f @@
src/sfs_pkg.sv
src/sfs_ram.sv
src/sfs_ctrl.sv
src/sfs_dp.sv
src/sprite_frame_sequencer.sv
bench/testbench.sv
